/* rtl/core/nnlr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nnlr_pkg;

	// Field widths fixed by the interface.
	localparam int COORD_W   = 6;
	localparam int PIXEL_W   = 32;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIZE = 1'b1;

	// Item function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Size registers come out of reset at this edge length.
	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd16;

endpackage

`default_nettype wire

/* rtl/core/nearest_neighbor_layer_rescale.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                                   Moves
// in        sink       in_valid/in_ready, func row col pixel_in  one write or read item
// out       source     out_valid/out_ready, pixel_out            one pixel per read item
// cfg       sink       cfg_valid/cfg_ready, cfg_index cfg_data   one register write
//
// One item enters per clock unless the output stalls. The pipeline is an entry stage
// that scales by the source size, a restoring divider that resolves one quotient bit per
// stage for row and column side by side, and the mapping and store-access stages.
// Reset clears all valid bits and sets both sizes to 16; the pixel store is not cleared.
// A stalled output freezes the whole pipeline; no item is lost or repeated.
module nearest_neighbor_layer_rescale
	import nnlr_pkg::*;
#(
	parameter int MAX_SIZE = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 func,
	input  wire logic [COORD_W-1:0]   row,
	input  wire logic [COORD_W-1:0]   col,
	input  wire logic [PIXEL_W-1:0]   pixel_in,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PIXEL_W-1:0]        pixel_out,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int IW    = $clog2(MAX_SIZE);
	localparam int SW    = $clog2(MAX_SIZE + 1);
	localparam int PW    = COORD_W + SW;
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic               func;
		logic [PIXEL_W-1:0] pix;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PW-1:0]      prod_r;
		logic [PW-1:0]      prod_c;
		logic [SW-1:0]      rem_r;
		logic [SW-1:0]      rem_c;
		logic [PW-1:0]      quo_r;
		logic [PW-1:0]      quo_c;
	} div_t;

	// Clamp a written size into [1, MAX_SIZE].
	function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] v);
		logic [SW-1:0] r;
		if (v == '0) begin
			r = SW'(1);
		end else if (32'(v) > MAX_SIZE) begin
			r = SW'(MAX_SIZE);
		end else begin
			r = SW'(v);
		end
		return r;
	endfunction

	// Saturate a mapped coordinate below the source size.
	function automatic logic [IW-1:0] sat_coord(input logic [PW-1:0] q,
			input logic [SW-1:0] src);
		logic [IW-1:0] r;
		if (q >= PW'(src)) begin
			r = IW'(src - SW'(1));
		end else begin
			r = IW'(q);
		end
		return r;
	endfunction

	logic [SW-1:0] src_q;
	logic [SW-1:0] tgt_q;
	logic          en;

	logic [PW:0]   vld_s;
	div_t          div_s [0:PW];
	div_t          div_nx [0:PW-1];

	logic          rd_s2;
	logic          we_s2;
	logic [AW-1:0] addr_s2;
	logic [PIXEL_W-1:0] pix_s2;

	logic          vld_s3;
	logic [PIXEL_W-1:0] rdata_s3;

	logic [PIXEL_W-1:0] store_q [0:DEPTH-1];

	// The whole pipeline moves unless a finished pixel waits at the output.
	assign en        = !vld_s3 || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_s3;
	assign pixel_out = rdata_s3;

	// Size registers, stored already clamped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SW'(SIZE_RESET);
			tgt_q <= SW'(SIZE_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_SIZE: src_q <= clamp_size(cfg_data);
				REG_TARGET_SIZE: tgt_q <= clamp_size(cfg_data);
				default: ;
			endcase
		end
	end

	// Entry stage: scale both coordinates by the source size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].func   <= func;
			div_s[0].pix    <= pixel_in;
			div_s[0].row    <= row;
			div_s[0].col    <= col;
			div_s[0].prod_r <= PW'(row) * PW'(src_q);
			div_s[0].prod_c <= PW'(col) * PW'(src_q);
			div_s[0].rem_r  <= '0;
			div_s[0].rem_c  <= '0;
			div_s[0].quo_r  <= '0;
			div_s[0].quo_c  <= '0;
		end
	end

	// Restoring divider by the target size, one quotient bit per stage.
	for (genvar k = 0; k < PW; k++) begin : g_div
		logic [SW:0] tr_r;
		logic [SW:0] tr_c;
		logic        ge_r;
		logic        ge_c;

		always_comb begin
			tr_r = {div_s[k].rem_r, div_s[k].prod_r[PW-1-k]};
			tr_c = {div_s[k].rem_c, div_s[k].prod_c[PW-1-k]};
			ge_r = tr_r >= {1'b0, tgt_q};
			ge_c = tr_c >= {1'b0, tgt_q};
			div_nx[k]       = div_s[k];
			div_nx[k].rem_r = ge_r ? SW'(tr_r - {1'b0, tgt_q}) : SW'(tr_r);
			div_nx[k].rem_c = ge_c ? SW'(tr_c - {1'b0, tgt_q}) : SW'(tr_c);
			div_nx[k].quo_r = {div_s[k].quo_r[PW-2:0], ge_r};
			div_nx[k].quo_c = {div_s[k].quo_c[PW-2:0], ge_c};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_nx[k];
			end
		end
	end

	// Mapping stage: saturate the quotients and form the store address for reads; writes use their own row and column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2 <= 1'b0;
			we_s2 <= 1'b0;
		end else if (en) begin
			rd_s2 <= vld_s[PW] && (div_s[PW].func == FUNC_READ);
			we_s2 <= vld_s[PW] && (div_s[PW].func == FUNC_WRITE)
				&& (32'(div_s[PW].row) < MAX_SIZE) && (32'(div_s[PW].col) < MAX_SIZE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2 <= div_s[PW].pix;
			if (div_s[PW].func == FUNC_READ) begin
				addr_s2 <= AW'(sat_coord(div_s[PW].quo_r, src_q)) * AW'(MAX_SIZE)
					+ AW'(sat_coord(div_s[PW].quo_c, src_q));
			end else begin
				addr_s2 <= AW'(div_s[PW].row) * AW'(MAX_SIZE) + AW'(div_s[PW].col);
			end
		end
	end

	// Store access: writes and reads keep item order through the one port pair.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we_s2) begin
				store_q[addr_s2] <= pix_s2;
			end
			if (rd_s2) begin
				rdata_s3 <= store_q[addr_s2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= rd_s2;
		end
	end

endmodule

`default_nettype wire
